[rtl/core/four_level_page_walker_core_macros.svh]
// ----------------------------------------------------------------------------
// Four-level page walker: assertion macros
// Short forms for the clocked implication checks used by the checker.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_WALKER_CORE_MACROS_SVH
`define FOUR_LEVEL_PAGE_WALKER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/fpw_pkg.sv]
// ----------------------------------------------------------------------------
// Four-level page walker package
// Field widths, operation and result codes, and the table walk helpers.
// ----------------------------------------------------------------------------
package fpw_pkg;

  localparam int unsigned VA_W     = 64;
  localparam int unsigned ENTRY_W  = 64;
  localparam int unsigned PA_W     = 52;
  localparam int unsigned SKIP_W   = 40;
  localparam int unsigned INDEX_W  = 9;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 4;

  // Input operation codes.
  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_ENTRY     = 1'b1
  } op_t;

  // Result kinds.
  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  // Walk status codes.
  typedef enum logic {
    STATUS_MAPPED  = 1'b0,
    STATUS_MISSING = 1'b1
  } status_t;

  // Register index of the root pointer (paddr bit 3 selects the register).
  localparam logic REG_PAGE_ROOT = 1'b0;

  // Region sizes reported for a zero entry at each upper level.
  localparam logic [SKIP_W-1:0] SKIP_512G = 40'h80_0000_0000;
  localparam logic [SKIP_W-1:0] SKIP_1G   = 40'h00_4000_0000;
  localparam logic [SKIP_W-1:0] SKIP_2M   = 40'h00_0020_0000;

  // Nine-bit table index of a virtual address at a given level.
  function automatic logic [INDEX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [LEVEL_W-1:0] level);
    logic [INDEX_W-1:0] idx;
    case (level)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      2'd3:    idx = va[20:12];
      default: idx = '0;
    endcase
    return idx;
  endfunction

  // Size of the region skipped when the entry at this level is zero.
  function automatic logic [SKIP_W-1:0] skip_size(input logic [LEVEL_W-1:0] level);
    logic [SKIP_W-1:0] size;
    case (level)
      2'd0:    size = SKIP_512G;
      2'd1:    size = SKIP_1G;
      2'd2:    size = SKIP_2M;
      default: size = '0;
    endcase
    return size;
  endfunction

endpackage

[rtl/core/four_level_page_walker_core.sv]
// ----------------------------------------------------------------------------
// Four-level page walker core
// Walks a four-level, 9-bit-index, 4 KiB-page table one entry at a time.
// The input channel carries translate requests (operation 0) and returned
// table entries (operation 1). Each accepted item that the walk uses gives
// one result item: either the address of the next entry to read or the
// finished walk (physical address, or a missing-table status with the
// size of the region that can be skipped). Requests while a walk is busy
// and entries while idle are dropped without a result.
// Results are registered: out_valid rises in the cycle after the item
// that gives the result is accepted, and an item can be accepted every
// cycle while in_stall is low; the memory round trip lies outside the block.
// The output register decouples the channels: in_stall rises only when a
// result is held and out_stall is high. A stalled result stays unchanged.
// Reset (rst_n low, synchronous) leaves the walker idle, clears the root
// pointer to zero and empties the output register.
// The root pointer is a 52-bit register at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module four_level_page_walker_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_operation,
  input  logic [fpw_pkg::VA_W-1:0]            in_virtual_address,
  input  logic [fpw_pkg::ENTRY_W-1:0]         in_table_entry,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_result_kind,
  output logic [fpw_pkg::PA_W-1:0]            out_read_address,
  output logic [fpw_pkg::PA_W-1:0]            out_physical_address,
  output logic                                out_status,
  output logic [fpw_pkg::SKIP_W-1:0]          out_skip_size,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fpw_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [fpw_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [fpw_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  // Configuration and walk state.
  logic [fpw_pkg::PA_W-1:0]    page_root_r;
  logic [fpw_pkg::VA_W-1:0]    held_address_r, held_address_nxt;
  logic [fpw_pkg::LEVEL_W-1:0] walk_level_r, walk_level_nxt;
  logic                        walk_busy_r, walk_busy_nxt;

  // Output register.
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_kind_r, out_kind_nxt;
  logic [fpw_pkg::PA_W-1:0]    out_raddr_r, out_raddr_nxt;
  logic [fpw_pkg::PA_W-1:0]    out_paddr_r, out_paddr_nxt;
  logic                        out_status_r, out_status_nxt;
  logic [fpw_pkg::SKIP_W-1:0]  out_skip_r, out_skip_nxt;

  logic                        in_accept;
  logic                        has_result;
  logic                        cfg_write;
  logic [fpw_pkg::LEVEL_W-1:0] next_level;

  // The input side waits only while a held result is stalled.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // APB register access.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[3] == fpw_pkg::REG_PAGE_ROOT)
                   ? {{(fpw_pkg::CFG_DATA_W - fpw_pkg::PA_W){1'b0}}, page_root_r}
                   : '0;

  assign next_level = walk_level_r + 2'd1;

  // Walk step: decide the result and the next walk state for one item.
  always_comb begin
    held_address_nxt = held_address_r;
    walk_level_nxt   = walk_level_r;
    walk_busy_nxt    = walk_busy_r;
    has_result       = 1'b0;
    out_kind_nxt     = fpw_pkg::KIND_READ;
    out_raddr_nxt    = '0;
    out_paddr_nxt    = '0;
    out_status_nxt   = fpw_pkg::STATUS_MAPPED;
    out_skip_nxt     = '0;
    if (in_operation == fpw_pkg::OP_TRANSLATE) begin
      if (!walk_busy_r) begin
        // New request: read the top-level entry.
        held_address_nxt = in_virtual_address;
        walk_level_nxt   = '0;
        walk_busy_nxt    = 1'b1;
        has_result       = 1'b1;
        out_raddr_nxt    = {page_root_r[fpw_pkg::PA_W-1:fpw_pkg::OFFSET_W],
                            fpw_pkg::level_index(in_virtual_address, 2'd0), 3'b000};
      end
    end else if (walk_busy_r) begin
      has_result = 1'b1;
      if (walk_level_r == 2'd3) begin
        // Page-table entry: frame plus page offset, presence not checked.
        walk_busy_nxt  = 1'b0;
        walk_level_nxt = '0;
        out_kind_nxt   = fpw_pkg::KIND_DONE;
        out_paddr_nxt  = {in_table_entry[fpw_pkg::PA_W-1:fpw_pkg::OFFSET_W],
                          held_address_r[fpw_pkg::OFFSET_W-1:0]};
      end else if (in_table_entry == '0) begin
        // Missing intermediate table ends the walk.
        walk_busy_nxt  = 1'b0;
        walk_level_nxt = '0;
        out_kind_nxt   = fpw_pkg::KIND_DONE;
        out_status_nxt = fpw_pkg::STATUS_MISSING;
        out_skip_nxt   = fpw_pkg::skip_size(walk_level_r);
      end else begin
        // Descend: read the entry of the next level.
        walk_level_nxt = next_level;
        out_raddr_nxt  = {in_table_entry[fpw_pkg::PA_W-1:fpw_pkg::OFFSET_W],
                          fpw_pkg::level_index(held_address_r, next_level), 3'b000};
      end
    end
  end

  // Output valid: load on a new result, clear once taken.
  always_comb begin
    if (in_accept && has_result) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_root_r    <= '0;
      held_address_r <= '0;
      walk_level_r   <= '0;
      walk_busy_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_write && paddr[3] == fpw_pkg::REG_PAGE_ROOT) begin
        page_root_r <= pwdata[fpw_pkg::PA_W-1:0];
      end
      if (in_accept) begin
        held_address_r <= held_address_nxt;
        walk_level_r   <= walk_level_nxt;
        walk_busy_r    <= walk_busy_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_accept && has_result) begin
      out_kind_r   <= out_kind_nxt;
      out_raddr_r  <= out_raddr_nxt;
      out_paddr_r  <= out_paddr_nxt;
      out_status_r <= out_status_nxt;
      out_skip_r   <= out_skip_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result_kind      = out_kind_r;
  assign out_read_address     = out_raddr_r;
  assign out_physical_address = out_paddr_r;
  assign out_status           = out_status_r;
  assign out_skip_size        = out_skip_r;

endmodule

[rtl/core/fpw_checker.sv]
// ----------------------------------------------------------------------------
// Four-level page walker checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "four_level_page_walker_core_macros.svh"

module fpw_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_result_kind,
  input logic [fpw_pkg::PA_W-1:0]   out_read_address,
  input logic [fpw_pkg::PA_W-1:0]   out_physical_address,
  input logic                       out_status,
  input logic [fpw_pkg::SKIP_W-1:0] out_skip_size
);

  // A stalled item stays valid in the next cycle.
  `FPW_ASSERT_NEXT(a_stall_holds_valid, clk, rst_n, out_valid && out_stall, out_valid,
    "result item dropped while stalled")

  // A stalled item keeps its payload.
  `FPW_ASSERT_NEXT(a_stall_holds_data, clk, rst_n, out_valid && out_stall,
    $stable(out_result_kind) && $stable(out_read_address) &&
    $stable(out_physical_address) && $stable(out_status) && $stable(out_skip_size),
    "result item changed while stalled")

  // A read request carries only the read address.
  `FPW_ASSERT_SAME(a_read_fields, clk, rst_n,
    out_valid && out_result_kind == fpw_pkg::KIND_READ,
    out_physical_address == '0 && out_status == fpw_pkg::STATUS_MAPPED &&
    out_skip_size == '0 && out_read_address[2:0] == 3'b000,
    "read request with stray fields")

  // A missing table reports a skip size and no address.
  `FPW_ASSERT_SAME(a_missing_fields, clk, rst_n,
    out_valid && out_status == fpw_pkg::STATUS_MISSING,
    out_result_kind == fpw_pkg::KIND_DONE && out_physical_address == '0 &&
    out_read_address == '0 && (out_skip_size == fpw_pkg::SKIP_512G ||
    out_skip_size == fpw_pkg::SKIP_1G || out_skip_size == fpw_pkg::SKIP_2M),
    "missing-table result with bad fields")

endmodule

bind four_level_page_walker_core fpw_checker u_fpw_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_result_kind      (out_result_kind),
  .out_read_address     (out_read_address),
  .out_physical_address (out_physical_address),
  .out_status           (out_status),
  .out_skip_size        (out_skip_size)
);

[dv/tb.sv]
// ----------------------------------------------------------------------------
// Four-level page walker core testbench
// Drives translate requests and returned table entries into the walker,
// predicts every read request and finished walk from its own copy of the
// walk state, and checks each result item field by field. Both channels
// idle and stall at random, and the root pointer is rewritten between
// phases while the walker is idle.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam logic [63:0] FRAME_BITS = 64'h000F_FFFF_FFFF_F000;
  localparam logic [fpw_pkg::CFG_ADDR_W-1:0] ROOT_ADDR = {fpw_pkg::REG_PAGE_ROOT, 3'b000};

  // One predicted result item.
  typedef struct {
    fpw_pkg::kind_t             kind;
    logic [fpw_pkg::PA_W-1:0]   read_address;
    logic [fpw_pkg::PA_W-1:0]   physical_address;
    fpw_pkg::status_t           status;
    logic [fpw_pkg::SKIP_W-1:0] skip_size;
  } walk_result_t;

  // Tracks the walk state and holds the results still to come.
  class page_walk_tracker;
    logic [fpw_pkg::PA_W-1:0] root;
    logic [63:0]     held_va;
    logic [1:0]      level;
    bit              busy;
    walk_result_t    pending_results[$];
    int              mismatches;
    int              checked;

    function new();
      root = '0;
      held_va = '0;
      level = '0;
      busy = 1'b0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_root(logic [63:0] value);
      root = value[fpw_pkg::PA_W-1:0];
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // Byte offset of the entry selected by the held address at a level.
    function logic [fpw_pkg::PA_W-1:0] entry_offset(logic [1:0] lvl);
      logic [63:0] shifted;
      shifted = held_va >> (39 - 9 * int'(lvl));
      return {40'd0, shifted[8:0], 3'b000};
    endfunction

    // Region that a zero entry at an upper level leaves unmapped.
    function logic [fpw_pkg::SKIP_W-1:0] region_size(logic [1:0] lvl);
      case (lvl)
        2'd0:    return 40'h80_0000_0000;
        2'd1:    return 40'h00_4000_0000;
        2'd2:    return 40'h00_0020_0000;
        default: return 40'd0;
      endcase
    endfunction

    // Called for every accepted input item.
    function void note_item(fpw_pkg::op_t op, logic [63:0] va, logic [63:0] entry);
      walk_result_t r;
      r.kind = fpw_pkg::KIND_READ;
      r.read_address = '0;
      r.physical_address = '0;
      r.status = fpw_pkg::STATUS_MAPPED;
      r.skip_size = '0;
      if (op == fpw_pkg::OP_TRANSLATE) begin
        // A request while a walk is running is dropped.
        if (busy) return;
        held_va = va;
        level = 2'd0;
        busy = 1'b1;
        r.read_address = (root & FRAME_BITS[fpw_pkg::PA_W-1:0]) + entry_offset(2'd0);
      end else begin
        // An entry with no walk running is dropped.
        if (!busy) return;
        if (level == 2'd3) begin
          busy = 1'b0;
          level = 2'd0;
          r.kind = fpw_pkg::KIND_DONE;
          r.physical_address = {entry[51:12], held_va[11:0]};
        end else if (entry == 64'd0) begin
          busy = 1'b0;
          r.kind = fpw_pkg::KIND_DONE;
          r.status = fpw_pkg::STATUS_MISSING;
          r.skip_size = region_size(level);
          level = 2'd0;
        end else begin
          level = level + 2'd1;
          r.read_address = {entry[51:12], 12'd0} + entry_offset(level);
        end
      end
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Called for every accepted result item.
    function void check_result(logic kind, logic [fpw_pkg::PA_W-1:0] raddr,
                               logic [fpw_pkg::PA_W-1:0] paddr, logic status,
                               logic [fpw_pkg::SKIP_W-1:0] skip);
      walk_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual kind=%0d raddr=%h paddr=%h",
                 $time, kind, raddr, paddr);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare_field("result_kind", 64'(want.kind), 64'(kind));
      compare_field("read_address", 64'(want.read_address), 64'(raddr));
      compare_field("physical_address", 64'(want.physical_address), 64'(paddr));
      compare_field("status", 64'(want.status), 64'(status));
      compare_field("skip_size", 64'(want.skip_size), 64'(skip));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_operation = 1'b0;
  logic [fpw_pkg::VA_W-1:0]     in_virtual_address = '0;
  logic [fpw_pkg::ENTRY_W-1:0]  in_table_entry = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_result_kind;
  logic [fpw_pkg::PA_W-1:0]     out_read_address;
  logic [fpw_pkg::PA_W-1:0]     out_physical_address;
  logic                out_status;
  logic [fpw_pkg::SKIP_W-1:0]   out_skip_size;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [fpw_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [fpw_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [fpw_pkg::CFG_DATA_W-1:0] prdata;
  logic                pready;

  page_walk_tracker tracker;
  bit          quiet_mode = 1'b0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;
  int          useful_items = 0;
  int          ignored_items = 0;
  int          walks = 0;
  int          root_settings = 0;

  four_level_page_walker_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_virtual_address   (in_virtual_address),
    .in_table_entry       (in_table_entry),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_result_kind      (out_result_kind),
    .out_read_address     (out_read_address),
    .out_physical_address (out_physical_address),
    .out_status           (out_status),
    .out_skip_size        (out_skip_size),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // Clock with a 12-unit period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sample both channels at the rising edge. Results are checked before the
  // new input is noted, since a result always comes from an earlier item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        tracker.check_result(out_result_kind, out_read_address, out_physical_address,
                             out_status, out_skip_size);
      end
      if (in_valid && !in_stall) begin
        tracker.note_item(fpw_pkg::op_t'(in_operation), in_virtual_address,
                          in_table_entry);
      end
    end
  end

  // Result-side stalls: mostly none, some short, a few long.
  always @(negedge clk) begin : stall_gen
    int pick;
    pick = $urandom_range(0, 99);
    if (!rst_n || quiet_mode) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (pick < 70) begin
      out_stall <= 1'b0;
    end else if (pick < 95) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(8, 30);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Sender gap before an item: mostly none, some short, a few long.
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet_mode || pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one item and hold it until it is accepted.
  task automatic send_item(fpw_pkg::op_t op, logic [63:0] va, logic [63:0] entry);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_operation <= op;
    in_virtual_address <= va;
    in_table_entry <= entry;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has come out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write of the root pointer: setup cycle, then access cycle.
  task automatic write_root(logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ROOT_ADDR;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_root(value);
    root_settings++;
  endtask

  // Hand-picked items: address extremes, flag bits, zero entries at every
  // level, and items that arrive in the wrong state.
  task automatic directed_checks();
    // Entry with no walk running, then a walk under the reset root.
    send_item(fpw_pkg::OP_ENTRY, rand64(), '1);
    send_item(fpw_pkg::OP_TRANSLATE, 64'd0, 64'd0);
    // Request while busy is dropped.
    send_item(fpw_pkg::OP_TRANSLATE, '1, '1);
    // Entries with all flag bits set still walk on their frame bits.
    send_item(fpw_pkg::OP_ENTRY, 64'd0, '1);
    send_item(fpw_pkg::OP_ENTRY, 64'd0, 64'h8000_0000_0000_0001);
    send_item(fpw_pkg::OP_ENTRY, 64'd0, '1);
    // A zero page-table entry still finishes as mapped with frame zero.
    send_item(fpw_pkg::OP_ENTRY, 64'd0, 64'd0);
    send_item(fpw_pkg::OP_ENTRY, '1, 64'd0);
    settle();
    // Root with its low bits and high bits set.
    write_root('1);
    send_item(fpw_pkg::OP_TRANSLATE, '1, '1);
    send_item(fpw_pkg::OP_ENTRY, '1, 64'd0);
    send_item(fpw_pkg::OP_TRANSLATE, 64'h0000_7FFF_FFFF_F123, 64'd0);
    send_item(fpw_pkg::OP_ENTRY, 64'd0, 64'h0000_0000_1234_5003);
    send_item(fpw_pkg::OP_ENTRY, 64'd0, 64'd0);
    send_item(fpw_pkg::OP_TRANSLATE, rand64(), 64'd0);
    send_item(fpw_pkg::OP_ENTRY, 64'd0, rand64() | 64'd1);
    send_item(fpw_pkg::OP_ENTRY, 64'd0, rand64() | 64'd1);
    send_item(fpw_pkg::OP_ENTRY, 64'd0, 64'd0);
    send_item(fpw_pkg::OP_TRANSLATE, '1, 64'd0);
    repeat (4) send_item(fpw_pkg::OP_ENTRY, 64'd0, '1);
    settle();
  endtask

  // One complete walk with random content and occasional dropped items.
  task automatic random_walk();
    logic [63:0] va;
    logic [63:0] entry;
    int          lvl;
    int          pick;
    bit          stop;
    pick = $urandom_range(0, 99);
    if (pick < 5) va = '0;
    else if (pick < 12) va = '1;
    else va = rand64();
    if ($urandom_range(0, 99) < 8) begin
      send_item(fpw_pkg::OP_ENTRY, rand64(), rand64());
      ignored_items++;
    end
    send_item(fpw_pkg::OP_TRANSLATE, va, rand64());
    useful_items++;
    walks++;
    stop = 1'b0;
    for (lvl = 0; lvl < 4 && !stop; lvl++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_item(fpw_pkg::OP_TRANSLATE, rand64(), rand64());
        ignored_items++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 11) begin
        entry = '0;
        stop = 1'b1;
      end else if (pick < 20) begin
        entry = (rand64() & 64'hFFF0_0000_0000_0FFF) | 64'd1;
      end else begin
        entry = rand64();
        if (entry == 64'd0) entry = 64'd1;
      end
      send_item(fpw_pkg::OP_ENTRY, rand64(), entry);
      useful_items++;
    end
  endtask

  initial begin
    logic [63:0] roots[6];
    int          phase;
    int          goal;
    tracker = new();
    roots[0] = rand64();
    roots[1] = 64'h0000_0000_0000_0FFF;
    roots[2] = 64'h000F_FFFF_FFFF_F000;
    roots[3] = rand64();
    roots[4] = 64'hFFF0_0000_0000_0000;
    roots[5] = rand64();

    // Hold reset low at the start, then release it at a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_checks();

    // Random phases, each under a new root; one phase runs without idling.
    for (phase = 0; phase < 6; phase++) begin
      write_root(roots[phase]);
      quiet_mode = (phase == 3);
      goal = useful_items + 165;
      while (useful_items < goal) begin
        random_walk();
        if ($urandom_range(0, 99) < 2) settle();
      end
      settle();
    end
    quiet_mode = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    $display("Ran %0d random walks and %0d dropped items under %0d root settings.",
             walks, ignored_items, root_settings);
    $display("Checked %0d results, %0d mismatches.", tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
